### rtl/core/tts_pkg.sv
// ----------------------------------------------------------------------------
// Tick task scheduler package
// Shared request and response types, operation and status codes, and the
// layout of one task slot entry held in the slot memory.
// ----------------------------------------------------------------------------
package tts_pkg;

   localparam int PERIOD_W = 16;
   localparam int PRIO_W   = 8;

   localparam logic [2:0] OP_SPAWN    = 3'd0;
   localparam logic [2:0] OP_START    = 3'd1;
   localparam logic [2:0] OP_STOP     = 3'd2;
   localparam logic [2:0] OP_SETPER   = 3'd3;
   localparam logic [2:0] OP_TICK     = 3'd4;
   localparam logic [2:0] OP_DISPATCH = 3'd5;
   localparam logic [2:0] OP_CLEAR    = 3'd6;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_UNUSED = 2'd2;

   localparam int MAX_RES = 8;

   typedef struct packed {
      logic [2:0]          req_type;
      logic [2:0]          slot_id;
      logic [PERIOD_W-1:0] task_period;
      logic [PRIO_W-1:0]   task_priority;
   } tts_req_type;

   typedef struct packed {
      logic [2:0]          result_slot;
      logic                slot_valid;
      logic [1:0]          status;
      logic                last_result;
      logic [3:0]          used_slots;
      logic [PERIOD_W-1:0] tick_count;
   } tts_rsp_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] countdown;
      logic [PRIO_W-1:0]   priority_lvl;
   } tts_entry_type;

   localparam int ENTRY_W = $bits(tts_entry_type);

   // Countdown value a slot is armed with: period less one, or zero for one-shot.
   function automatic logic [PERIOD_W-1:0] arm_value(input logic [PERIOD_W-1:0] p);
      return (p == '0) ? '0 : p - 1'b1;
   endfunction

endpackage

### rtl/core/tts_ram.sv
// ----------------------------------------------------------------------------
// Tick task scheduler RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module tts_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/tick_task_scheduler.sv
// ----------------------------------------------------------------------------
// Tick task scheduler
// A table of periodic task slots with a tick counter and a priority
// dispatcher. Marks live in flip-flops; period, countdown and priority live
// in one slot memory that is read, modified and written back.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload    Direction
//  request   start / busy          req_item   in
//  response  rsp_valid (strobe)    rsp_item   out
//
// Spawn, stop, clear and no-op requests go straight to their result; start
// and set period on a used slot first pass a read-modify-write state, since
// the slot entry is read from the memory and written back. A tick reads each
// slot in turn and writes back the updated countdown of each used, enabled
// slot in the cycle after its read, then gives its result. A dispatch runs one
// scan over all slots for each slot it emits (at most eight scans, plus one if
// fewer are ready), then sends its results one after another through the
// output register. Results are strobed for a single cycle and cannot be stalled.
// Reset is synchronous and clears all marks and the tick counter; the memory
// needs no clearing, because only entries of slots marked used are acted on.
// ----------------------------------------------------------------------------
module tick_task_scheduler #(
   parameter int SLOTS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tts_pkg::tts_req_type req_item,
   output logic                 rsp_valid,
   output tts_pkg::tts_rsp_type rsp_item
);

   import tts_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RMW  = 3'd1;
   localparam logic [2:0] S_TICK = 3'd2;
   localparam logic [2:0] S_DISP = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [SLOTS-1:0] used_ff, used_in;
   logic [SLOTS-1:0] en_ff, en_in;
   logic [SLOTS-1:0] rdy_ff, rdy_in;
   logic [15:0]      tick_ff, tick_in;
   tts_req_type      req_ff, req_in;

   // Scan pipeline: one slot address issued per cycle, compared in the cycle after.
   logic [IW-1:0]    scan_idx_ff, scan_idx_in;
   logic             scan_run_ff, scan_run_in;
   logic             cmp_v_ff, cmp_v_in;
   logic [IW-1:0]    cmp_idx_ff, cmp_idx_in;

   // Best candidate found so far in the current dispatch scan.
   logic             have_ff, have_in;
   logic [IW-1:0]    best_ff, best_in;
   logic [PRIO_W-1:0]   best_prio_ff, best_prio_in;
   logic [PERIOD_W-1:0] best_per_ff, best_per_in;

   // Result list for the current request.
   logic [2:0]       res_slot_ff [MAX_RES];
   logic [2:0]       res_slot_in [MAX_RES];
   logic [3:0]       res_n_ff, res_n_in;
   logic             res_valid_ff, res_valid_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [2:0]       emit_ff, emit_in;

   logic             rsp_valid_ff, rsp_valid_in;
   tts_rsp_type      rsp_ff, rsp_in;

   // Slot memory ports.
   logic             ram_we;
   logic [IW-1:0]    ram_waddr;
   tts_entry_type    ram_wdata;
   logic [IW-1:0]    ram_raddr;
   tts_entry_type    ram_rdata;

   logic             accept;
   logic [IW-1:0]    id_idx;
   logic             id_ok;
   logic [IW-1:0]    free_idx;
   logic             free_found;
   logic [6:0]       used_cnt;
   logic [3:0]       used_sat;

   // Dispatch compare terms.
   logic             elig;
   logic             cand;
   logic             have_n;
   logic [IW-1:0]    best_n;
   logic [PERIOD_W-1:0] best_per_n;
   logic [3:0]       new_n;
   logic             emit_last;

   tts_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // A slot number is only meaningful when it lies inside the table and is used.
   assign id_idx = IW'(req_item.slot_id);
   assign id_ok  = ({4'd0, req_item.slot_id} < 7'(SLOTS)) && used_ff[id_idx];

   // The lowest free slot is the one a spawn takes.
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx   = IW'(i);
            free_found = 1'b1;
         end
      end
   end

   assign used_cnt = 7'($countones(used_ff));
   assign used_sat = (used_cnt > 7'd15) ? 4'd15 : used_cnt[3:0];

   // Dispatch candidate: strictly lower priority wins, so ties keep the lower slot.
   assign elig       = used_ff[cmp_idx_ff] && en_ff[cmp_idx_ff] && rdy_ff[cmp_idx_ff];
   assign cand       = elig && (!have_ff || (ram_rdata.priority_lvl < best_prio_ff));
   assign have_n     = have_ff || cand;
   assign best_n     = cand ? cmp_idx_ff : best_ff;
   assign best_per_n = cand ? ram_rdata.period : best_per_ff;
   assign new_n      = res_n_ff + {3'd0, have_n};
   assign emit_last  = (({1'b0, emit_ff} + 4'd1) == res_n_ff);

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      en_in         = en_ff;
      rdy_in        = rdy_ff;
      tick_in       = tick_ff;
      req_in        = req_ff;
      scan_idx_in   = scan_idx_ff;
      scan_run_in   = scan_run_ff;
      cmp_v_in      = scan_run_ff;
      cmp_idx_in    = scan_idx_ff;
      have_in       = have_ff;
      best_in       = best_ff;
      best_prio_in  = best_prio_ff;
      best_per_in   = best_per_ff;
      res_slot_in   = res_slot_ff;
      res_n_in      = res_n_ff;
      res_valid_in  = res_valid_ff;
      res_status_in = res_status_ff;
      emit_in       = emit_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = cmp_idx_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = scan_idx_ff;

      // The scan address counter runs whenever a scan is active.
      if (scan_run_ff) begin
         if (scan_idx_ff == LAST_IDX) begin
            scan_run_in = 1'b0;
         end else begin
            scan_idx_in = scan_idx_ff + 1'b1;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in        = req_item;
               res_n_in      = 4'd1;
               res_valid_in  = 1'b0;
               res_status_in = ST_OK;
               emit_in       = '0;
               state_in      = S_EMIT;
               ram_raddr     = id_idx;
               unique case (req_item.req_type)
                  OP_SPAWN: begin
                     if (free_found) begin
                        ram_we                 = 1'b1;
                        ram_waddr              = free_idx;
                        ram_wdata.period       = req_item.task_period;
                        ram_wdata.countdown    = arm_value(req_item.task_period);
                        ram_wdata.priority_lvl = req_item.task_priority;
                        used_in[free_idx]      = 1'b1;
                        en_in[free_idx]        = 1'b1;
                        rdy_in[free_idx]       = 1'b0;
                        res_slot_in[0]         = 3'(free_idx);
                        res_valid_in           = 1'b1;
                     end else begin
                        res_status_in = ST_FULL;
                     end
                  end
                  OP_START, OP_SETPER: begin
                     if (id_ok) begin
                        state_in = S_RMW;
                     end else begin
                        res_status_in = ST_UNUSED;
                     end
                  end
                  OP_STOP: begin
                     if (id_ok) begin
                        en_in[id_idx]  = 1'b0;
                        rdy_in[id_idx] = 1'b0;
                     end else begin
                        res_status_in = ST_UNUSED;
                     end
                  end
                  OP_TICK: begin
                     tick_in     = tick_ff + 16'd1;
                     scan_idx_in = '0;
                     scan_run_in = 1'b1;
                     state_in    = S_TICK;
                  end
                  OP_DISPATCH: begin
                     res_n_in    = 4'd0;
                     have_in     = 1'b0;
                     scan_idx_in = '0;
                     scan_run_in = 1'b1;
                     state_in    = S_DISP;
                  end
                  OP_CLEAR: begin
                     used_in = '0;
                     en_in   = '0;
                     rdy_in  = '0;
                     tick_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_RMW: begin
            ram_we    = 1'b1;
            ram_waddr = IW'(req_ff.slot_id);
            if (req_ff.req_type == OP_START) begin
               ram_wdata.countdown = arm_value(ram_rdata.period);
               en_in[IW'(req_ff.slot_id)]  = 1'b1;
               rdy_in[IW'(req_ff.slot_id)] = 1'b0;
            end else begin
               ram_wdata.period = req_ff.task_period;
            end
            state_in = S_EMIT;
         end

         S_TICK: begin
            if (cmp_v_ff) begin
               if (used_ff[cmp_idx_ff] && en_ff[cmp_idx_ff]) begin
                  if (ram_rdata.countdown == '0) begin
                     rdy_in[cmp_idx_ff] = 1'b1;
                     if (ram_rdata.period != '0) begin
                        ram_we              = 1'b1;
                        ram_wdata.countdown = arm_value(ram_rdata.period);
                     end
                  end else begin
                     ram_we              = 1'b1;
                     ram_wdata.countdown = ram_rdata.countdown - 1'b1;
                  end
               end
               if (cmp_idx_ff == LAST_IDX) begin
                  state_in = S_EMIT;
               end
            end
         end

         S_DISP: begin
            if (cmp_v_ff) begin
               if (cmp_idx_ff != LAST_IDX) begin
                  have_in      = have_n;
                  best_in      = best_n;
                  best_prio_in = cand ? ram_rdata.priority_lvl : best_prio_ff;
                  best_per_in  = best_per_n;
               end else begin
                  // End of one scan: take the winner out of the ready set, and free it if one-shot.
                  if (have_n) begin
                     rdy_in[best_n] = 1'b0;
                     if (best_per_n == '0) begin
                        used_in[best_n] = 1'b0;
                        en_in[best_n]   = 1'b0;
                     end
                     res_slot_in[res_n_ff[2:0]] = 3'(best_n);
                     res_n_in = new_n;
                  end
                  if (have_n && (new_n != 4'(MAX_RES))) begin
                     have_in     = 1'b0;
                     scan_idx_in = '0;
                     scan_run_in = 1'b1;
                  end else begin
                     res_valid_in = (new_n != 4'd0);
                     res_n_in     = (new_n == 4'd0) ? 4'd1 : new_n;
                     state_in     = S_EMIT;
                  end
               end
            end
         end

         S_EMIT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.result_slot = res_valid_ff ? res_slot_ff[emit_ff] : 3'd0;
            rsp_in.slot_valid  = res_valid_ff;
            rsp_in.status      = res_status_ff;
            rsp_in.last_result = emit_last;
            rsp_in.used_slots  = used_sat;
            rsp_in.tick_count  = tick_ff;
            emit_in            = emit_ff + 1'b1;
            if (emit_last) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         en_ff        <= '0;
         rdy_ff       <= '0;
         tick_ff      <= '0;
         scan_run_ff  <= 1'b0;
         cmp_v_ff     <= 1'b0;
         have_ff      <= 1'b0;
         res_n_ff     <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         en_ff        <= en_in;
         rdy_ff       <= rdy_in;
         tick_ff      <= tick_in;
         scan_run_ff  <= scan_run_in;
         cmp_v_ff     <= cmp_v_in;
         have_ff      <= have_in;
         res_n_ff     <= res_n_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      scan_idx_ff   <= scan_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_ff       <= best_in;
      best_prio_ff  <= best_prio_in;
      best_per_ff   <= best_per_in;
      res_slot_ff   <= res_slot_in;
      res_valid_ff  <= res_valid_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

`ifndef SYNTHESIS
   // A slot can only be enabled while used, and only ready while enabled.
   a_marks_nested: assert property (@(posedge clock) disable iff (reset)
      ((en_ff & ~used_ff) == '0) && ((rdy_ff & ~en_ff) == '0))
      else $error("slot marks out of order");

   // A result only appears while a request is being worked on.
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a request");

   // An accepted transfer always makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request accepted but block not busy");

   // The final result of a request returns the block to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last_result) |-> !busy)
      else $error("block still busy after final result");
`endif

endmodule
